FILE: rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants of the gap buffer text store.
// ----------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int ACT_W     = 3;
  localparam int CH_W      = 8;
  localparam int IDX_W     = 10;
  localparam int ST_W      = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_LEFT   = 3'd2,
    ACT_RIGHT  = 3'd3,
    ACT_READ   = 3'd4
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EDGE  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RD   = 1'b1
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/gbts_mem.sv
// ----------------------------------------------------------------------------
// gbts_mem
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/gap_buffer_text_store_unit.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_unit
// Gap buffer editor core: insert, delete, cursor moves and indexed reads.
//
// Input channel (in_valid/in_ready) carries one action per beat; the result
// channel (out_valid/out_ready) returns exactly one beat per action with the
// read character, the cursor, the text length and a status code.
// Insert, delete, refused actions and unused codes need no memory read and
// post their result in the cycle after acceptance.
// Moves and reads read the character store (registered read data) in S_RD,
// then write back or return the byte once the output register is free, and
// the next beat is taken no earlier than that.
// The result sits in an output register; a new beat is accepted while it
// waits only if it is being taken in the same cycle. A stalled receiver
// holds the block in place with no loss.
// Reset (rst_n low, synchronous) empties the text: cursor 0, gap end at
// DEPTH-1. Store contents are not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_store_unit
  import gbts_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ACT_W-1:0] in_action,
  input  wire logic [CH_W-1:0]  in_ch,
  input  wire logic [IDX_W-1:0] in_text_index,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [CH_W-1:0]       out_char_out,
  output logic [IDX_W-1:0]      out_cursor,
  output logic [IDX_W-1:0]      out_text_length,
  output logic [ST_W-1:0]       out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + IDX_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  state_t        state_r, state_nxt;
  act_t          act_r, act_nxt;
  logic [AW-1:0] gs_r, gs_nxt;
  logic [AW-1:0] ge_r, ge_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [CH_W-1:0] char_r;
  logic [IDX_W-1:0] cursor_r, len_r;
  status_t         status_r;

  logic            out_load;
  logic [CH_W-1:0] char_nxt;
  status_t         st_nxt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [CH_W-1:0] mem_wdata, mem_rdata;

  logic            in_fire;
  logic [CW-1:0]   idx_ext, len_ext, gs_ext, phys_ext;
  logic [AW-1:0]   len_cur;
  logic [CW-1:0]   cur_out_ext, len_out_ext;

  gbts_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CH_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // stored characters = text before the gap + text after it
  assign len_cur  = gs_r + (LAST - ge_r);
  assign idx_ext  = CW'(in_text_index);
  assign len_ext  = CW'(len_cur);
  assign gs_ext   = CW'(gs_r);
  assign phys_ext = (idx_ext < gs_ext) ? idx_ext
                  : idx_ext + CW'(ge_r) - gs_ext + CW'(1);

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    gs_nxt    = gs_r;
    ge_nxt    = ge_r;
    out_load  = 1'b0;
    char_nxt  = '0;
    st_nxt    = ST_OK;
    mem_we    = 1'b0;
    mem_waddr = gs_r;
    mem_wdata = in_ch;
    mem_re    = 1'b0;
    mem_raddr = gs_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt  = act_t'(in_action);
          out_load = 1'b1;
          unique case (in_action)
            ACT_INSERT: begin
              if (gs_r == ge_r) begin
                st_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = gs_r;
                mem_wdata = in_ch;
                gs_nxt    = gs_r + 1'b1;
              end
            end
            ACT_DELETE: begin
              if (gs_r == '0) begin
                st_nxt = ST_EDGE;
              end else begin
                gs_nxt = gs_r - 1'b1;
              end
            end
            ACT_LEFT: begin
              if (gs_r == '0) begin
                st_nxt = ST_EDGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = gs_r - 1'b1;
                out_load  = 1'b0;
                state_nxt = S_RD;
              end
            end
            ACT_RIGHT: begin
              if (ge_r == LAST) begin
                st_nxt = ST_EDGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ge_r + 1'b1;
                out_load  = 1'b0;
                state_nxt = S_RD;
              end
            end
            ACT_READ: begin
              if (idx_ext >= len_ext) begin
                st_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = phys_ext[AW-1:0];
                out_load  = 1'b0;
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        // read data is valid; finish once the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          unique case (act_r)
            ACT_LEFT: begin
              mem_we    = 1'b1;
              mem_waddr = ge_r;
              mem_wdata = mem_rdata;
              gs_nxt    = gs_r - 1'b1;
              ge_nxt    = ge_r - 1'b1;
            end
            ACT_RIGHT: begin
              mem_we    = 1'b1;
              mem_waddr = gs_r;
              mem_wdata = mem_rdata;
              gs_nxt    = gs_r + 1'b1;
              ge_nxt    = ge_r + 1'b1;
            end
            ACT_READ: begin
              char_nxt = mem_rdata;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cur_out_ext   = CW'(gs_nxt);
  assign len_out_ext   = CW'(gs_nxt + (LAST - ge_nxt));
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_INSERT;
      gs_r        <= '0;
      ge_r        <= LAST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_r   <= char_nxt;
      cursor_r <= cur_out_ext[IDX_W-1:0];
      len_r    <= len_out_ext[IDX_W-1:0];
      status_r <= st_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = char_r;
  assign out_cursor      = cursor_r;
  assign out_text_length = len_r;
  assign out_status      = status_r;

  // the gap never closes completely
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    gs_r <= ge_r)
    else $error("gap start passed gap end");

  a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_INSERT && gs_r != ge_r)
      |=> (gs_r == $past(gs_r) + 1'b1))
    else $error("insert did not advance the cursor");

  a_rd_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> !in_ready)
    else $error("beat accepted during memory read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending beat");

endmodule

`default_nettype wire
